// ----- rtl/bdcc_pkg.sv -----
`default_nettype none

package bdcc_pkg;

	// Widths of the configuration port and of the result fields.
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CLASS_W     = 2;
	localparam int unsigned COUNT_W     = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS   = 2'd1;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST = 16'd20;
	localparam logic [CFG_DATA_W-1:0] WINDOW_TICKS_RST   = 16'd1000;

	// Highest click class: three or more presses.
	localparam logic [CLASS_W-1:0] CLASS_MORE = 2'd3;

	// Button phases, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_PRESS_DEB = 5'b00010,
		PH_WAIT_REL  = 5'b00100,
		PH_REL_DEB   = 5'b01000,
		PH_WINDOW    = 5'b10000
	} phase_t;

	// One result item as the core computes it.
	typedef struct packed {
		logic [CLASS_W-1:0] click_class;
		logic [COUNT_W-1:0] press_count;
		logic               debouncing;
		logic               window_open;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/bdcc_in_if.sv -----
`default_nettype none

interface bdcc_in_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic clear_count;

	modport source (output valid, output pin_level, output clear_count, input ready);
	modport sink (input valid, input pin_level, input clear_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdcc_out_if.sv -----
`default_nettype none

interface bdcc_out_if;
	import bdcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] click_class;
	logic [COUNT_W-1:0] press_count;
	logic               debouncing;
	logic               window_open;

	modport source (output valid, output click_class, output press_count,
		output debouncing, output window_open, input ready);
	modport sink (input valid, input click_class, input press_count,
		input debouncing, input window_open, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdcc_core.sv -----
`default_nettype none

module bdcc_core #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic                            pin_level,
	input  wire logic                            clear_count,
	input  wire logic [bdcc_pkg::CFG_DATA_W-1:0] debounce_ticks,
	input  wire logic [bdcc_pkg::CFG_DATA_W-1:0] window_ticks,
	output      bdcc_pkg::result_t               result_next
);
	import bdcc_pkg::*;

	// Compare width covers both the timer and the 16-bit registers.
	localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] deb_elapsed_q, deb_elapsed_d;
	logic [TIMER_WIDTH-1:0] win_elapsed_q, win_elapsed_d;
	logic                   edge_seen_q, edge_seen_d;
	logic                   prev_level_q;
	logic [COUNT_W-1:0]     presses_q, presses_d;
	logic                   deb_flag_q, deb_flag_d;
	logic                   win_flag_q, win_flag_d;

	logic [CMP_W-1:0]       deb_cmp, win_cmp, deb_lim, win_lim;
	logic                   deb_expired, win_expired;

	assign deb_lim = CMP_W'(debounce_ticks);
	assign win_lim = CMP_W'(window_ticks);

	// Next state for one tick.
	always_comb begin
		presses_d     = clear_count ? '0 : presses_q;
		edge_seen_d   = edge_seen_q | (pin_level & ~prev_level_q);
		deb_elapsed_d = deb_elapsed_q;
		win_elapsed_d = win_elapsed_q;
		deb_flag_d    = deb_flag_q;
		win_flag_d    = win_flag_q;
		phase_d       = phase_q;

		// Both timers saturate at all ones.
		if ((phase_q == PH_PRESS_DEB || phase_q == PH_REL_DEB) && !(&deb_elapsed_q)) begin
			deb_elapsed_d = deb_elapsed_q + 1'b1;
		end
		if (win_flag_q && !(&win_elapsed_q)) begin
			win_elapsed_d = win_elapsed_q + 1'b1;
		end

		deb_cmp     = CMP_W'(deb_elapsed_d);
		win_cmp     = CMP_W'(win_elapsed_d);
		deb_expired = deb_cmp >= deb_lim;
		win_expired = win_cmp >= win_lim;

		unique case (phase_q)
			PH_PRESS_DEB, PH_REL_DEB: begin
				if (deb_expired) begin
					if (!edge_seen_d) begin
						if (phase_q == PH_PRESS_DEB) begin
							phase_d = PH_WAIT_REL;
						end else begin
							phase_d    = PH_WINDOW;
							deb_flag_d = 1'b0;
						end
					end else begin
						deb_elapsed_d = '0;
					end
					edge_seen_d = 1'b0;
				end
			end
			PH_WAIT_REL: begin
				if (!pin_level) begin
					phase_d       = PH_REL_DEB;
					deb_elapsed_d = '0;
				end
			end
			PH_WINDOW: begin
				if (win_expired) begin
					win_flag_d = 1'b0;
					phase_d    = PH_IDLE;
				end else if (pin_level) begin
					deb_flag_d    = 1'b1;
					deb_elapsed_d = '0;
					if (!(&presses_d)) presses_d = presses_d + 1'b1;
					edge_seen_d   = 1'b0;
					phase_d       = PH_PRESS_DEB;
				end
			end
			default: begin
				// Idle, and any code outside the five phases.
				if (pin_level) begin
					win_flag_d    = 1'b1;
					win_elapsed_d = '0;
					deb_flag_d    = 1'b1;
					deb_elapsed_d = '0;
					if (!(&presses_d)) presses_d = presses_d + 1'b1;
					edge_seen_d   = 1'b0;
					phase_d       = PH_PRESS_DEB;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Result as seen after the tick.
	always_comb begin
		result_next.click_class = (presses_d >= COUNT_W'(CLASS_MORE)) ? CLASS_MORE
			: CLASS_W'(presses_d);
		result_next.press_count = presses_d;
		result_next.debouncing  = deb_flag_d;
		result_next.window_open = win_flag_d;
	end

	// State registers advance once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			deb_elapsed_q <= '0;
			win_elapsed_q <= '0;
			edge_seen_q   <= 1'b0;
			prev_level_q  <= 1'b0;
			presses_q     <= '0;
			deb_flag_q    <= 1'b0;
			win_flag_q    <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			deb_elapsed_q <= deb_elapsed_d;
			win_elapsed_q <= win_elapsed_d;
			edge_seen_q   <= edge_seen_d;
			prev_level_q  <= pin_level;
			presses_q     <= presses_d;
			deb_flag_q    <= deb_flag_d;
			win_flag_q    <= win_flag_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/button_debounce_click_counter.sv -----
`default_nettype none

// Channel   Direction  Payload
// sample    in         pin_level, clear_count
// result    out        click_class, press_count, debouncing, window_open
// config    in         cfg_wr_en, cfg_index, cfg_wdata (0 debounce_ticks, 1 window_ticks)
//
// Each sample gives exactly one result. A sample is registered in the input
// stage, then processed by the phase logic into the result register, and one
// sample can be accepted every cycle while the result channel does not stall.
// Reset returns the phase machine, timers and press count to idle and zero,
// and the registers to 20 and 1000. A stalled result holds the pipeline: a
// new sample is taken only when the input stage can move forward.
module button_debounce_click_counter #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bdcc_in_if.sink                               sample,
	bdcc_out_if.source                            result,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bdcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bdcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import bdcc_pkg::*;

	logic [CFG_DATA_W-1:0] debounce_ticks_q;
	logic [CFG_DATA_W-1:0] window_ticks_q;

	logic    valid_s1;
	logic    pin_level_s1;
	logic    clear_count_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t result_next;
	logic    out_free;
	logic    step;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_TICKS_RST;
			window_ticks_q   <= WINDOW_TICKS_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_DEBOUNCE_TICKS) debounce_ticks_q <= cfg_wdata;
			if (cfg_index == CFG_WINDOW_TICKS)   window_ticks_q   <= cfg_wdata;
		end
	end

	// Handshake: the result register frees when empty or taken.
	assign out_free     = !out_valid_q || result.ready;
	assign step         = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			pin_level_s1   <= sample.pin_level;
			clear_count_s1 <= sample.clear_count;
		end
	end

	// Phase machine, timers and press counter.
	bdcc_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.pin_level      (pin_level_s1),
		.clear_count    (clear_count_s1),
		.debounce_ticks (debounce_ticks_q),
		.window_ticks   (window_ticks_q),
		.result_next    (result_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result_next;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.click_class = out_q.click_class;
	assign result.press_count = out_q.press_count;
	assign result.debouncing  = out_q.debouncing;
	assign result.window_open = out_q.window_open;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
	import bdcc_pkg::*;

	localparam int unsigned TIMER_W       = 16;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned LONG_HOLD     = 80;
	localparam int unsigned RUN_LIMIT     = 5_000_000;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Directed ticks as {pin_level, clear_count}: a press with chatter, an edge
	// during release debounce, a second press while the window runs out, and a
	// fresh sequence with clears.
	localparam logic [1:0] PRESS_SCRIPT [24] = '{
		2'b00, 2'b11, 2'b00, 2'b10, 2'b10, 2'b10, 2'b10, 2'b00,
		2'b10, 2'b00, 2'b00, 2'b00, 2'b10, 2'b10, 2'b10, 2'b00,
		2'b00, 2'b00, 2'b10, 2'b11, 2'b10, 2'b00, 2'b00, 2'b01
	};

	typedef logic [TIMER_W-1:0] tick_count_t;

	// Tracks the button state machine tick by tick and holds the readings
	// that the block owes us, oldest first.
	class click_tracker;
		tick_count_t                  debounce_ticks;
		tick_count_t                  window_ticks;
		phase_t                       phase;
		tick_count_t                  debounce_elapsed;
		tick_count_t                  window_elapsed;
		logic                         edge_seen;
		logic                         previous_level;
		logic [COUNT_W-1:0]           presses;
		logic                         debounce_flag;
		logic                         window_flag;
		result_t                      expected_readings[$];
		int unsigned                  mismatches;
		int unsigned                  readings_checked;
		logic [COUNT_W-1:0]           peak_presses;

		function new();
			debounce_ticks   = DEBOUNCE_TICKS_RST;
			window_ticks     = WINDOW_TICKS_RST;
			phase            = PH_IDLE;
			debounce_elapsed = '0;
			window_elapsed   = '0;
			edge_seen        = 1'b0;
			previous_level   = 1'b0;
			presses          = '0;
			debounce_flag    = 1'b0;
			window_flag      = 1'b0;
			mismatches       = 0;
			readings_checked = 0;
			peak_presses     = '0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_DEBOUNCE_TICKS: debounce_ticks = value;
				CFG_WINDOW_TICKS:   window_ticks = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_readings.size();
		endfunction

		// Timers stop at their top value instead of wrapping.
		function tick_count_t bump(tick_count_t value);
			return (value == '1) ? value : value + 1'b1;
		endfunction

		// A press starts a debounce interval and counts, saturating at the top.
		function void count_press();
			debounce_flag    = 1'b1;
			debounce_elapsed = '0;
			if (presses != '1)
				presses = presses + 1'b1;
			edge_seen = 1'b0;
			phase     = PH_PRESS_DEB;
		endfunction

		// Advances the machine by one accepted sample and queues its reading.
		function void take_sample(logic pin, logic clr);
			result_t reading;
			if (clr)
				presses = '0;
			if (pin && !previous_level)
				edge_seen = 1'b1;
			if (phase == PH_PRESS_DEB || phase == PH_REL_DEB)
				debounce_elapsed = bump(debounce_elapsed);
			if (window_flag)
				window_elapsed = bump(window_elapsed);

			case (phase)
				PH_PRESS_DEB, PH_REL_DEB: begin
					// An edge inside the interval restarts it; a quiet interval moves on.
					if (debounce_elapsed >= debounce_ticks) begin
						if (!edge_seen) begin
							if (phase == PH_PRESS_DEB) begin
								phase = PH_WAIT_REL;
							end else begin
								phase         = PH_WINDOW;
								debounce_flag = 1'b0;
							end
						end else begin
							debounce_elapsed = '0;
						end
						edge_seen = 1'b0;
					end
				end
				PH_WAIT_REL: begin
					if (!pin) begin
						phase            = PH_REL_DEB;
						debounce_elapsed = '0;
					end
				end
				PH_WINDOW: begin
					if (window_elapsed >= window_ticks) begin
						window_flag = 1'b0;
						phase       = PH_IDLE;
					end else if (pin) begin
						count_press();
					end
				end
				default: begin
					// The first press of a sequence opens the click window.
					if (pin) begin
						window_flag    = 1'b1;
						window_elapsed = '0;
						count_press();
					end else begin
						phase = PH_IDLE;
					end
				end
			endcase
			previous_level = pin;

			if (presses > peak_presses)
				peak_presses = presses;
			reading.click_class = (presses >= CLASS_MORE) ? CLASS_MORE : presses[CLASS_W-1:0];
			reading.press_count = presses;
			reading.debouncing  = debounce_flag;
			reading.window_open = window_flag;
			expected_readings.push_back(reading);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_reading(result_t got);
			result_t want;
			if (expected_readings.size() == 0) begin
				$error("result transfer with no sample outstanding");
				mismatches++;
				return;
			end
			want = expected_readings.pop_front();
			readings_checked++;
			compare_field("click_class", want.click_class, got.click_class);
			compare_field("press_count", want.press_count, got.press_count);
			compare_field("debouncing", want.debouncing, got.debouncing);
			compare_field("window_open", want.window_open, got.window_open);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	bdcc_in_if  sample_ch ();
	bdcc_out_if result_ch ();

	click_tracker board;

	int unsigned samples_sent;
	int unsigned settings_used;
	int unsigned clear_permille;
	int unsigned sender_idle_pct;
	int unsigned stall_pct;
	bit          hold_pending;

	button_debounce_click_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_left    = LONG_HOLD;
				hold_pending = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Every result transfer is checked against the oldest expected reading.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_reading(result_t'({result_ch.click_class, result_ch.press_count,
				result_ch.debouncing, result_ch.window_open}));
	end

	// Offers one sample, with random gaps ahead of it, and waits for the transfer.
	// Entered and left at a falling edge.
	task automatic send_sample(logic pin, logic clr);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.pin_level   <= pin;
		sample_ch.clear_count <= clr;
		do @(posedge clk); while (!sample_ch.ready);
		board.take_sample(pin, clr);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic tick(logic pin);
		send_sample(pin, $urandom_range(999) < clear_permille);
	endtask

	// Stops offering and waits until every reading has come back.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.set_register(index, value);
		@(negedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] debounce, logic [CFG_DATA_W-1:0] window,
		int unsigned idle_pct, int unsigned stall, int unsigned clear_rate);
		wait_drained();
		write_reg(CFG_DEBOUNCE_TICKS, debounce);
		write_reg(CFG_WINDOW_TICKS, window);
		sender_idle_pct = idle_pct;
		stall_pct       = stall;
		clear_permille  = clear_rate;
		settings_used++;
	endtask

	// One press as a person makes it: optional chatter on the way down, a hold,
	// optional chatter on the way up, then a released gap.
	task automatic press_sequence(int unsigned hold_max, int unsigned gap_max,
		int unsigned bounce_pct);
		int unsigned chatter;
		chatter = ($urandom_range(99) < bounce_pct) ? $urandom_range(3, 1) : 0;
		repeat (chatter) begin
			tick(1'b1);
			tick(1'b0);
		end
		repeat ($urandom_range(hold_max, 1)) tick(1'b1);
		chatter = ($urandom_range(99) < bounce_pct) ? $urandom_range(3, 1) : 0;
		repeat (chatter) begin
			tick(1'b0);
			tick(1'b1);
		end
		repeat ($urandom_range(gap_max, 1)) tick(1'b0);
	endtask

	// Mostly well-formed presses, with bursts of random levels in between.
	task automatic run_random(int unsigned n_items, int unsigned hold_max,
		int unsigned gap_max, int unsigned bounce_pct);
		int unsigned stop_at;
		stop_at = samples_sent + n_items;
		while (samples_sent < stop_at) begin
			if ($urandom_range(99) < 85)
				press_sequence(hold_max, gap_max, bounce_pct);
			else
				repeat ($urandom_range(6, 1)) tick(1'($urandom_range(1)));
		end
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.pin_level   = 1'b0;
		sample_ch.clear_count = 1'b0;
		samples_sent          = 0;
		settings_used         = 1;
		clear_permille        = 5;
		sender_idle_pct       = 0;
		stall_pct             = 0;
		hold_pending          = 1'b0;
		board                 = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register values from reset, both sides always ready.
		run_random(80, 45, 60, 50);

		// Spare indexes must leave both registers alone.
		wait_drained();
		write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom_range(16'hFFFF)));
		write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom_range(16'hFFFF)));

		// Short intervals so the directed ticks walk through every phase.
		configure(16'd2, 16'd14, 75, 0, 0);
		foreach (PRESS_SCRIPT[i])
			send_sample(PRESS_SCRIPT[i][1], PRESS_SCRIPT[i][0]);

		configure(16'd3, 16'd40, 0, 75, 10);
		run_random(100, 8, 30, 40);

		// Zero intervals expire at the first check.
		configure(16'd0, 16'd0, 23, 23, 10);
		run_random(80, 3, 4, 50);

		// Fastest presses inside one long window.
		configure(16'd1, 16'hFFFF, 0, 0, 0);
		repeat (25) press_sequence(1, 4, 0);
		run_random(30, 2, 4, 30);

		// Longest intervals: the machine stays in debounce for the whole phase.
		configure(16'hFFFF, 16'hFFFF, 75, 0, 20);
		run_random(30, 4, 4, 50);

		// Long hold-off on results while samples keep coming, then a full drain.
		configure(16'd5, 16'd100, 23, 23, 10);
		run_random(50, 12, 50, 40);
		hold_pending = 1'b1;
		run_random(50, 12, 50, 40);
		wait_drained();
		run_random(60, 12, 50, 40);

		configure(16'd7, 16'd30, 0, 75, 30);
		run_random(80, 16, 40, 40);

		wait_drained();
		$display("Sent %0d samples under %0d register settings, idle and stall mixes included.",
			samples_sent, settings_used);
		$display("Checked %0d results; press count reached %0d.",
			board.readings_checked, board.peak_presses);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
